// ===== hdl/spc_pkg.sv =====
// Shared types, constants and arithmetic helpers for the scan point clustering block.
// Used by spc_front, spc_back and scan_point_clustering_top; depends on nothing.
package spc_pkg;

  localparam int RANGE_W  = 16;
  localparam int ANGLE_W  = 9;
  localparam int ANGLE_LAST = 511;
  localparam int COORD_W  = 17;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int SQ_CFG_W = 32;

  // Q30 sine generator, used at elaboration only
  localparam int Q_BITS = 30;
  localparam logic [63:0] HALF_PI_Q = 64'd1686629713;
  localparam logic [63:0] TAYLOR_DIV [13] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210,
    64'd272, 64'd342, 64'd420, 64'd506, 64'd600, 64'd702
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_RANGE = 2'd0,
    CFG_GAP       = 2'd1,
    CFG_MIN_WIDTH = 2'd2,
    CFG_MAX_WIDTH = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    BK_LOAD   = 1'b0,
    BK_DECIDE = 1'b1
  } bk_state_e;

  typedef struct packed {
    logic [RANGE_W-1:0]  max_range;
    logic [SQ_CFG_W-1:0] gap_sq;
    logic [SQ_CFG_W-1:0] min_sq;
    logic [SQ_CFG_W-1:0] max_sq;
  } cfg_t;

  // One classified sample on its way from front to back
  typedef struct packed {
    logic               keep;
    logic               last;
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
  } mid_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic               valid;
    logic               scan_end;
  } res_t;

  // sin(x) for x in [0, pi/2], argument and result in Q30
  function automatic logic [63:0] sin_q(input logic [63:0] x);
    logic [63:0] term;
    logic [63:0] sum;
    term = x;
    sum  = x;
    for (int k = 1; k <= 13; k++) begin
      term = (term * x) >> Q_BITS;
      term = (term * x) >> Q_BITS;
      term = term / TAYLOR_DIV[k-1];
      if ((k % 2) == 1) begin
        sum = (sum > term) ? sum - term : 64'd0;
      end else begin
        sum = sum + term;
      end
    end
    if (sum > (64'd1 << Q_BITS)) begin
      sum = 64'd1 << Q_BITS;
    end
    return sum;
  endfunction

  // (a + b) / 2 rounded to nearest, ties away from zero
  function automatic logic [COORD_W-1:0] half_round(input logic [COORD_W-1:0] a,
                                                   input logic [COORD_W-1:0] b);
    logic [COORD_W:0]   s;
    logic [COORD_W:0]   mag;
    logic [COORD_W-1:0] m;
    s   = {a[COORD_W-1], a} + {b[COORD_W-1], b};
    mag = s[COORD_W] ? (~s + 1'b1) : s;
    m   = COORD_W'((mag + 1'b1) >> 1);
    return s[COORD_W] ? (~m + 1'b1) : m;
  endfunction

endpackage

// ===== hdl/spc_fifo.sv =====
// Small first-in first-out queue in flip-flops, show-ahead read.
// Generic; no package dependency.
module spc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ===== hdl/spc_front.sv =====
// Front part: takes samples, filters by range, looks up sine and cosine, forms x/y.
// Depends on spc_pkg.
module spc_front import spc_pkg::*; #(
  parameter int ANGLE_STEPS    = 360,
  parameter int SINE_FRAC_BITS = 14
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               push_i,
  output logic               full_o,
  input  logic [RANGE_W-1:0] range_mm_i,
  input  logic [ANGLE_W-1:0] angle_deg_i,
  input  logic               last_sample_i,
  input  logic               mid_full_i,
  output logic               mid_push_o,
  output mid_item_t          mid_item_o
);

  localparam int F    = SINE_FRAC_BITS;
  localparam int SW   = F + 2;
  localparam int MW   = F + 1;
  localparam int PW   = RANGE_W + MW;
  localparam int AW   = $clog2(ANGLE_STEPS);
  localparam int RW   = (AW > ANGLE_W) ? AW : ANGLE_W;
  localparam int NSUB = ANGLE_LAST / ANGLE_STEPS;

  typedef logic signed [SW-1:0] tab_t [ANGLE_STEPS];

  // Table entry at p quarter-steps of a turn
  function automatic logic signed [SW-1:0] make_entry(input logic [63:0] p);
    logic [63:0] quad;
    logic [63:0] rem;
    logic [63:0] x;
    logic [63:0] mag;
    quad = p / ANGLE_STEPS;
    rem  = p % ANGLE_STEPS;
    x    = rem * HALF_PI_Q / ANGLE_STEPS;
    if (quad[0]) begin
      x = HALF_PI_Q - x;
    end
    mag = sin_q(x);
    mag = (mag + (64'd1 << (Q_BITS - F - 1))) >> (Q_BITS - F);
    return (quad >= 64'd2) ? -$signed(mag[SW-1:0]) : $signed(mag[SW-1:0]);
  endfunction

  function automatic tab_t build_tab(input logic cos_sel);
    tab_t        t;
    logic [63:0] p;
    for (int i = 0; i < ANGLE_STEPS; i++) begin
      p = 64'(4 * i);
      if (cos_sel) begin
        p = p + 64'(ANGLE_STEPS);
        if (p >= 64'(4 * ANGLE_STEPS)) begin
          p = p - 64'(4 * ANGLE_STEPS);
        end
      end
      t[i] = make_entry(p);
    end
    return t;
  endfunction

  localparam tab_t SIN_TAB = build_tab(1'b0);
  localparam tab_t COS_TAB = build_tab(1'b1);

  logic                 accept;
  logic [RW-1:0]        ang;
  logic [AW-1:0]        idx;
  logic                 a_valid_q, a_valid_d;
  logic [RANGE_W-1:0]   a_r_q;
  logic                 a_keep_q;
  logic                 a_last_q;
  logic signed [SW-1:0] sin_rd_q;
  logic signed [SW-1:0] cos_rd_q;
  logic [MW-1:0]        sin_mag, cos_mag;
  logic [PW-1:0]        sin_prod, cos_prod;
  logic [PW-1:0]        sin_rnd, cos_rnd;
  logic [COORD_W-1:0]   sin_m, cos_m;

  assign full_o     = a_valid_q && mid_full_i;
  assign accept     = push_i && !full_o;
  assign mid_push_o = a_valid_q && !mid_full_i;

  // Fold the angle into one turn
  always_comb begin
    ang = RW'(angle_deg_i);
    for (int k = 0; k < NSUB; k++) begin
      if (ang >= RW'(ANGLE_STEPS)) begin
        ang = ang - RW'(ANGLE_STEPS);
      end
    end
    idx = ang[AW-1:0];
  end

  assign a_valid_d = accept || (a_valid_q && mid_full_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_r_q    <= range_mm_i;
      a_keep_q <= (range_mm_i != '0) && (range_mm_i < cfg_i.max_range);
      a_last_q <= last_sample_i;
      sin_rd_q <= SIN_TAB[idx];
      cos_rd_q <= COS_TAB[idx];
    end
  end

  // r * |table| / 2^F, rounded half away from zero
  always_comb begin
    sin_mag  = sin_rd_q[SW-1] ? MW'(-sin_rd_q) : MW'(sin_rd_q);
    cos_mag  = cos_rd_q[SW-1] ? MW'(-cos_rd_q) : MW'(cos_rd_q);
    sin_prod = PW'(a_r_q) * PW'(sin_mag);
    cos_prod = PW'(a_r_q) * PW'(cos_mag);
    sin_rnd  = (sin_prod + (PW'(1) << (F - 1))) >> F;
    cos_rnd  = (cos_prod + (PW'(1) << (F - 1))) >> F;
    sin_m    = sin_rnd[COORD_W-1:0];
    cos_m    = cos_rnd[COORD_W-1:0];
  end

  always_comb begin
    mid_item_o.keep = a_keep_q;
    mid_item_o.last = a_last_q;
    mid_item_o.px   = sin_rd_q[SW-1] ? sin_m : (~sin_m + 1'b1);
    mid_item_o.py   = cos_rd_q[SW-1] ? (~cos_m + 1'b1) : cos_m;
  end

endmodule

// ===== hdl/spc_back.sv =====
// Back part: squared gap and width, cluster open/close decisions, result items.
// Depends on spc_pkg.
module spc_back import spc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      mid_empty_i,
  input  mid_item_t mid_item_i,
  output logic      mid_pop_o,
  input  logic      out_full_i,
  output logic      out_push_o,
  output res_t      out_item_o
);

  localparam int DW = COORD_W + 1;
  localparam int SQW = 2 * DW - 1;

  bk_state_e          state_q, state_d;
  mid_item_t          item_q;
  logic [COORD_W-1:0] prev_x_q, prev_x_d, prev_y_q, prev_y_d;
  logic [COORD_W-1:0] start_x_q, start_x_d, start_y_q, start_y_d;
  logic               prev_valid_q, prev_valid_d;
  logic               open_q, open_d;
  logic [SQW-1:0]     dxsq_q, dysq_q, wxsq_q, wysq_q;

  logic signed [DW-1:0]   dx, dy, wx, wy;
  logic signed [2*DW-1:0] dx_sq, dy_sq, wx_sq, wy_sq;
  logic [SQW:0]           d2, w2;
  logic                   load;
  logic                   report;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_LOAD:   if (load) state_d = BK_DECIDE;
      BK_DECIDE: state_d = BK_LOAD;
      default:   state_d = BK_LOAD;
    endcase
  end

  // Outputs
  always_comb begin
    load       = 1'b0;
    out_push_o = 1'b0;
    case (state_q)
      BK_LOAD:   load = !mid_empty_i && !out_full_i;
      BK_DECIDE: out_push_o = report || item_q.last;
      default:   load = 1'b0;
    endcase
  end

  assign mid_pop_o = load;

  // Differences and squares
  always_comb begin
    dx    = $signed({prev_x_q[COORD_W-1], prev_x_q})
          - $signed({mid_item_i.px[COORD_W-1], mid_item_i.px});
    dy    = $signed({prev_y_q[COORD_W-1], prev_y_q})
          - $signed({mid_item_i.py[COORD_W-1], mid_item_i.py});
    wx    = $signed({start_x_q[COORD_W-1], start_x_q})
          - $signed({prev_x_q[COORD_W-1], prev_x_q});
    wy    = $signed({start_y_q[COORD_W-1], start_y_q})
          - $signed({prev_y_q[COORD_W-1], prev_y_q});
    dx_sq = dx * dx;
    dy_sq = dy * dy;
    wx_sq = wx * wx;
    wy_sq = wy * wy;
  end

  // Decide
  always_comb begin
    d2           = {1'b0, dxsq_q} + {1'b0, dysq_q};
    w2           = {1'b0, wxsq_q} + {1'b0, wysq_q};
    report       = 1'b0;
    prev_x_d     = prev_x_q;
    prev_y_d     = prev_y_q;
    start_x_d    = start_x_q;
    start_y_d    = start_y_q;
    prev_valid_d = prev_valid_q;
    open_d       = open_q;
    if (state_q == BK_DECIDE) begin
      if (item_q.keep) begin
        if (prev_valid_q) begin
          if (!open_q && (d2 < (SQW+1)'(cfg_i.gap_sq))) begin
            start_x_d = prev_x_q;
            start_y_d = prev_y_q;
            open_d    = 1'b1;
          end else if (open_q && (d2 > (SQW+1)'(cfg_i.gap_sq))) begin
            report = (w2 > (SQW+1)'(cfg_i.min_sq)) && (w2 < (SQW+1)'(cfg_i.max_sq));
            open_d = 1'b0;
          end
        end
        prev_x_d     = item_q.px;
        prev_y_d     = item_q.py;
        prev_valid_d = 1'b1;
      end
      // Drop everything at scan end
      if (item_q.last) begin
        prev_valid_d = 1'b0;
        open_d       = 1'b0;
      end
    end
  end

  always_comb begin
    out_item_o.cx       = report ? half_round(start_x_q, prev_x_q) : '0;
    out_item_o.cy       = report ? half_round(start_y_q, prev_y_q) : '0;
    out_item_o.valid    = report;
    out_item_o.scan_end = item_q.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= BK_LOAD;
      prev_valid_q <= 1'b0;
      open_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      prev_valid_q <= prev_valid_d;
      open_q       <= open_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prev_x_q  <= prev_x_d;
    prev_y_q  <= prev_y_d;
    start_x_q <= start_x_d;
    start_y_q <= start_y_d;
    if (load) begin
      item_q <= mid_item_i;
      dxsq_q <= dx_sq[SQW-1:0];
      dysq_q <= dy_sq[SQW-1:0];
      wxsq_q <= wx_sq[SQW-1:0];
      wysq_q <= wy_sq[SQW-1:0];
    end
  end

endmodule

// ===== hdl/scan_point_clustering_top.sv =====
// Top level of the scan point clustering block: config registers, front, queues, back.
// Depends on spc_pkg, spc_fifo, spc_front and spc_back.
//
// Laser scan clustering. Push one range sample per beam (range, angle, last-sample
// flag); pop result items for reported clusters and one item at the end of every scan.
// Samples that are zero or not below max_range_mm are skipped; kept samples become
// x = -r*sin, y = r*cos from sine and cosine tables built at elaboration (no clearing
// pass after reset). The back part sets the sustained rate: it takes no new item until
// it has decided the last, squaring the gap and width as it loads an item and making the
// cluster decision in its decide state. The front accepts one item per cycle while its
// output is not held by a full queue to the back, into a registered table lookup and a
// combinational multiply; a two-entry queue sits between front and back and a two-entry
// result queue drives the result ports, so either side may stall on its own. Write
// configuration only while no item is in flight.
module scan_point_clustering_top import spc_pkg::*; #(
  parameter int ANGLE_STEPS    = 360,
  parameter int SINE_FRAC_BITS = 14
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // sample queue side
  input  logic                 push,
  output logic                 full,
  input  logic [RANGE_W-1:0]   range_mm_i,
  input  logic [ANGLE_W-1:0]   angle_deg_i,
  input  logic                 last_sample_i,
  // result queue side
  output logic                 empty,
  input  logic                 pop,
  output logic [COORD_W-1:0]   center_x_mm_o,
  output logic [COORD_W-1:0]   center_y_mm_o,
  output logic                 cluster_valid_o,
  output logic                 scan_end_o,
  // configuration writes
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  localparam int QUEUE_DEPTH = 2;

  cfg_t      cfg_q;
  mid_item_t front_item, mid_head;
  logic      mid_push, mid_pop, mid_full, mid_empty;
  res_t      res_item, res_head;
  logic      res_push, res_full;
  logic [SQ_CFG_W-1:0] data_sq;

  // Hold the gap and width limits squared so the back part compares squared distances directly
  assign data_sq = SQ_CFG_W'(cfg_data_i) * SQ_CFG_W'(cfg_data_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_range <= RANGE_W'(1000);
      cfg_q.gap_sq    <= SQ_CFG_W'(10000);
      cfg_q.min_sq    <= SQ_CFG_W'(2500);
      cfg_q.max_sq    <= SQ_CFG_W'(40000);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MAX_RANGE: cfg_q.max_range <= cfg_data_i;
        CFG_GAP:       cfg_q.gap_sq    <= data_sq;
        CFG_MIN_WIDTH: cfg_q.min_sq    <= data_sq;
        CFG_MAX_WIDTH: cfg_q.max_sq    <= data_sq;
        default:       cfg_q.max_range <= cfg_q.max_range;
      endcase
    end
  end

  // Filter and convert to x/y
  spc_front #(
    .ANGLE_STEPS    (ANGLE_STEPS),
    .SINE_FRAC_BITS (SINE_FRAC_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .push_i        (push),
    .full_o        (full),
    .range_mm_i    (range_mm_i),
    .angle_deg_i   (angle_deg_i),
    .last_sample_i (last_sample_i),
    .mid_full_i    (mid_full),
    .mid_push_o    (mid_push),
    .mid_item_o    (front_item)
  );

  // Decouple front from back
  spc_fifo #(
    .WIDTH ($bits(mid_item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .wdata_i (front_item),
    .pop_i   (mid_pop),
    .rdata_o (mid_head),
    .full_o  (mid_full),
    .empty_o (mid_empty)
  );

  // Cluster tracking
  spc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .mid_empty_i (mid_empty),
    .mid_item_i  (mid_head),
    .mid_pop_o   (mid_pop),
    .out_full_i  (res_full),
    .out_push_o  (res_push),
    .out_item_o  (res_item)
  );

  // Hold results until popped
  spc_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_item),
    .pop_i   (pop),
    .rdata_o (res_head),
    .full_o  (res_full),
    .empty_o (empty)
  );

  assign center_x_mm_o   = res_head.cx;
  assign center_y_mm_o   = res_head.cy;
  assign cluster_valid_o = res_head.valid;
  assign scan_end_o      = res_head.scan_end;

endmodule

// ===== bench/spc_cluster_checker.sv =====
`timescale 1ns / 1ps
// Checker for scan_point_clustering_top: watches the sample, result and config ports,
// predicts cluster centers and scan ends, and compares them. Depends on spc_pkg.
module spc_cluster_checker import spc_pkg::*; #(
  parameter int STEPS = 360,
  parameter int FRAC  = 14
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  input  logic               full,
  input  logic [RANGE_W-1:0] range_mm_i,
  input  logic [ANGLE_W-1:0] angle_deg_i,
  input  logic               last_sample_i,
  input  logic               empty,
  input  logic               pop,
  input  logic [COORD_W-1:0] center_x_mm_i,
  input  logic [COORD_W-1:0] center_y_mm_i,
  input  logic               cluster_valid_i,
  input  logic               scan_end_i,
  input  logic               cfg_we_i,
  input  cfg_idx_e           cfg_idx_i,
  input  logic [CFG_W-1:0]   cfg_data_i,
  output int                 errors_o,
  output int                 pending_o,
  output int                 clusters_o,
  output int                 scans_o
);

  localparam logic [63:0] QUARTER_TURN_Q30 = 64'd1686629713;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               hit;
    logic               eos;
  } center_item_t;

  center_item_t    centers_due[$];
  int              sin_lut[STEPS];
  int              cos_lut[STEPS];
  longint unsigned lim_range, gap_len, width_lo, width_hi;
  int              last_x, last_y, open_x, open_y;
  bit              have_last, in_cluster;

  // Taylor series of sin in Q30, truncating after every step
  function automatic longint unsigned sine_q30(input longint unsigned x);
    longint unsigned term, acc, div;
    term = x;
    acc  = x;
    for (int k = 1; k <= 13; k++) begin
      div  = longint'((2 * k) * (2 * k + 1));
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / div;
      if (k % 2 == 1) begin
        acc = (acc > term) ? acc - term : 64'd0;
      end else begin
        acc = acc + term;
      end
    end
    if (acc > (64'd1 << 30)) begin
      acc = 64'd1 << 30;
    end
    return acc;
  endfunction

  // p counts quarter steps of a turn: 4*STEPS per full turn
  function automatic int grid_sine(input longint unsigned p);
    longint unsigned quad, rem, x, mag;
    quad = p / STEPS;
    rem  = p % STEPS;
    x    = rem * QUARTER_TURN_Q30 / STEPS;
    if (quad[0]) begin
      x = QUARTER_TURN_Q30 - x;
    end
    mag = sine_q30(x);
    mag = (mag + (64'd1 << (29 - FRAC))) >> (30 - FRAC);
    return (quad >= 2) ? -int'(mag) : int'(mag);
  endfunction

  function automatic int scale_mm(input int r, input int s);
    longint unsigned m;
    m = longint'(r) * longint'(s < 0 ? -s : s);
    m = (m + (64'd1 << (FRAC - 1))) >> FRAC;
    return (s < 0) ? -int'(m) : int'(m);
  endfunction

  function automatic longint unsigned sq_dist(input int ax, input int ay,
                                              input int bx, input int by);
    longint dx, dy;
    dx = longint'(ax) - longint'(bx);
    dy = longint'(ay) - longint'(by);
    return longint'(dx * dx) + longint'(dy * dy);
  endfunction

  function automatic int mid_round(input int v);
    int m;
    m = (v < 0) ? -v : v;
    m = (m + 1) / 2;
    return (v < 0) ? -m : m;
  endfunction

  task automatic clear_segment();
    last_x     = 0;
    last_y     = 0;
    open_x     = 0;
    open_y     = 0;
    have_last  = 0;
    in_cluster = 0;
  endtask

  // Run one accepted sample through the breakpoint logic; queue any result
  task automatic segment_sample(input int r, input int ang, input bit last);
    int              a, px, py, cx, cy;
    bit              hit;
    longint unsigned d2, g2, w2;
    center_item_t    due;
    a   = ang % STEPS;
    hit = 0;
    cx  = 0;
    cy  = 0;
    if (r != 0 && longint'(r) < lim_range) begin
      px = -scale_mm(r, sin_lut[a]);
      py = scale_mm(r, cos_lut[a]);
      if (have_last) begin
        d2 = sq_dist(last_x, last_y, px, py);
        g2 = gap_len * gap_len;
        if (!in_cluster && d2 < g2) begin
          open_x     = last_x;
          open_y     = last_y;
          in_cluster = 1;
        end else if (in_cluster && d2 > g2) begin
          w2 = sq_dist(open_x, open_y, last_x, last_y);
          if (w2 > width_lo * width_lo && w2 < width_hi * width_hi) begin
            hit = 1;
            cx  = mid_round(open_x + last_x);
            cy  = mid_round(open_y + last_y);
          end
          in_cluster = 0;
        end
      end
      last_x    = px;
      last_y    = py;
      have_last = 1;
    end
    if (last) begin
      clear_segment();
    end
    if (hit || last) begin
      due.x   = cx[COORD_W-1:0];
      due.y   = cy[COORD_W-1:0];
      due.hit = hit;
      due.eos = last;
      centers_due.insert(centers_due.size(), due);
    end
  endtask

  initial begin
    for (int i = 0; i < STEPS; i++) begin
      sin_lut[i] = grid_sine(longint'(4 * i));
      cos_lut[i] = grid_sine(longint'((4 * i + STEPS) % (4 * STEPS)));
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    center_item_t got;
    if (!rst_ni) begin
      lim_range  = 1000;
      gap_len    = 100;
      width_lo   = 50;
      width_hi   = 200;
      errors_o   = 0;
      clusters_o = 0;
      scans_o    = 0;
      clear_segment();
      centers_due.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MAX_RANGE: lim_range = cfg_data_i;
          CFG_GAP:       gap_len   = cfg_data_i;
          CFG_MIN_WIDTH: width_lo  = cfg_data_i;
          CFG_MAX_WIDTH: width_hi  = cfg_data_i;
          default: ;
        endcase
      end
      if (push && !full) begin
        segment_sample(int'(range_mm_i), int'(angle_deg_i), last_sample_i);
      end
      if (pop && !empty) begin
        if (centers_due.size() == 0) begin
          $error("result item with nothing expected: x=%0d y=%0d valid=%0b end=%0b",
                 $signed(center_x_mm_i), $signed(center_y_mm_i), cluster_valid_i, scan_end_i);
          errors_o++;
        end else begin
          got = centers_due.pop_front();
          if (center_x_mm_i !== got.x) begin
            $error("center_x_mm: expected %0d, got %0d", $signed(got.x),
                   $signed(center_x_mm_i));
            errors_o++;
          end
          if (center_y_mm_i !== got.y) begin
            $error("center_y_mm: expected %0d, got %0d", $signed(got.y),
                   $signed(center_y_mm_i));
            errors_o++;
          end
          if (cluster_valid_i !== got.hit) begin
            $error("cluster_valid: expected %0b, got %0b", got.hit, cluster_valid_i);
            errors_o++;
          end
          if (scan_end_i !== got.eos) begin
            $error("scan_end: expected %0b, got %0b", got.eos, scan_end_i);
            errors_o++;
          end
          if (got.hit) clusters_o++;
          if (got.eos) scans_o++;
        end
      end
    end
    pending_o = centers_due.size();
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the scan_point_clustering_top bench: clock, reset, sample and config stimulus,
// result pacing and verdict. Depends on spc_pkg, spc_cluster_checker and the block's RTL.
module tb_top;
  import spc_pkg::*;

  localparam int ANGLE_STEPS    = 360;
  localparam int SINE_FRAC_BITS = 14;
  // Longest correct stretch without a handshake is the receiver hold-off plus a
  // few sender gaps and the pipeline latency; allow many times that.
  localparam int STALL_LIMIT    = 2000;
  localparam int HOLD_CYCLES    = 120;
  // Let samples that give no result drain too.
  localparam int SETTLE_CYCLES  = 8;
  localparam int PHASE_ITEMS    = 50;

  logic               clk           = 1'b0;
  logic               rst_n         = 1'b0;
  logic               push          = 1'b0;
  logic               full;
  logic [RANGE_W-1:0] range_mm      = '0;
  logic [ANGLE_W-1:0] angle_deg     = '0;
  logic               last_sample   = 1'b0;
  logic               empty;
  logic               pop           = 1'b0;
  logic [COORD_W-1:0] center_x_mm;
  logic [COORD_W-1:0] center_y_mm;
  logic               cluster_valid;
  logic               scan_end;
  logic               cfg_we        = 1'b0;
  cfg_idx_e           cfg_idx       = CFG_MAX_RANGE;
  logic [CFG_W-1:0]   cfg_data      = '0;

  int errors, pending, clusters, scans;
  int items_sent   = 0;
  int settings     = 0;
  int burst_left   = 0;
  int idle_cycles  = 0;
  int cur_range    = 1000;
  int cur_gap      = 100;
  bit hold_req     = 0;
  bit drain        = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  scan_point_clustering_top #(
    .ANGLE_STEPS    (ANGLE_STEPS),
    .SINE_FRAC_BITS (SINE_FRAC_BITS)
  ) dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .push            (push),
    .full            (full),
    .range_mm_i      (range_mm),
    .angle_deg_i     (angle_deg),
    .last_sample_i   (last_sample),
    .empty           (empty),
    .pop             (pop),
    .center_x_mm_o   (center_x_mm),
    .center_y_mm_o   (center_y_mm),
    .cluster_valid_o (cluster_valid),
    .scan_end_o      (scan_end),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data)
  );

  spc_cluster_checker #(
    .STEPS (ANGLE_STEPS),
    .FRAC  (SINE_FRAC_BITS)
  ) cluster_chk (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .push            (push),
    .full            (full),
    .range_mm_i      (range_mm),
    .angle_deg_i     (angle_deg),
    .last_sample_i   (last_sample),
    .empty           (empty),
    .pop             (pop),
    .center_x_mm_i   (center_x_mm),
    .center_y_mm_i   (center_y_mm),
    .cluster_valid_i (cluster_valid),
    .scan_end_i      (scan_end),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .errors_o        (errors),
    .pending_o       (pending),
    .clusters_o      (clusters),
    .scans_o         (scans)
  );

  // Watchdog: any cycle without an accepted item on either side counts toward the limit
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("scan_point_clustering_top regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: switch between random pop patterns; on request hold off for a
  // long stretch so the result queue and then the sample queue back up.
  initial begin : receiver
    int cyc;
    int mode;
    cyc  = 0;
    mode = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 0;
        pop <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (drain) begin
        pop <= 1'b1;
      end else begin
        case (mode)
          0: pop <= 1'b1;
          1: pop <= 1'($urandom_range(0, 1));
          2: pop <= ($urandom_range(0, 3) == 0);
          default: pop <= (cyc % 4 != 0);
        endcase
        cyc++;
        if (cyc % 50 == 0) mode = $urandom_range(0, 3);
      end
    end
  end

  // Drop push for a random gap; scramble the idle payload so it can't leak into results
  task automatic sender_gap();
    int n;
    n = $urandom_range(1, 10);
    repeat (n) begin
      @(negedge clk);
      push        <= 1'b0;
      range_mm    <= RANGE_W'($urandom);
      angle_deg   <= ANGLE_W'($urandom);
      last_sample <= 1'($urandom);
    end
  endtask

  // Offer one item and hold it until accepted; bursts are broken by random gaps
  task automatic send_item(input int r, input int a, input bit last);
    if (burst_left == 0) begin
      sender_gap();
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    @(negedge clk);
    push        <= 1'b1;
    range_mm    <= r[RANGE_W-1:0];
    angle_deg   <= a[ANGLE_W-1:0];
    last_sample <= last;
    @(posedge clk);
    while (full) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_noise();
    send_item($urandom_range(0, 65535), $urandom_range(0, 511), $urandom_range(0, 9) == 0);
  endtask

  // Wait until every expected result is out, then let result-free samples drain
  task automatic wait_idle();
    @(negedge clk);
    push <= 1'b0;
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input int value);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value[CFG_W-1:0];
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  task automatic apply_setting(input int max_range, input int gap, input int wmin,
                               input int wmax);
    wait_idle();
    write_reg(CFG_MAX_RANGE, max_range);
    write_reg(CFG_GAP, gap);
    write_reg(CFG_MIN_WIDTH, wmin);
    write_reg(CFG_MAX_WIDTH, wmax);
    cur_range = max_range;
    cur_gap   = gap;
    settings++;
  endtask

  // One scan sweeping consecutive beams: runs of near-constant range form objects,
  // separated by dropouts, far returns, random ranges and stray beam angles.
  task automatic run_scan(input int samples);
    int ang, seg_left, kind, base, span, r, a;
    ang      = $urandom_range(0, ANGLE_STEPS - 1);
    seg_left = 0;
    kind     = 0;
    base     = 0;
    for (int i = 0; i < samples; i++) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(1, 24);
        kind     = $urandom_range(0, 9);
        if (cur_range < 16) base = $urandom_range(1, 65535);
        else base = $urandom_range(cur_range / 8, cur_range - 1);
      end
      seg_left--;
      a = ang;
      case (kind)
        0, 1, 2, 3, 4, 5: begin
          span = (cur_gap / 2 > 4000) ? 4000 : cur_gap / 2;
          r    = base + int'($urandom_range(0, span)) - span / 2;
          if (r < 0) r = 0;
          if (r > 65535) r = 65535;
        end
        6: r = 0;
        7: r = $urandom_range(cur_range, 65535);
        8: r = $urandom_range(0, 65535);
        default: begin
          r = $urandom_range(0, 65535);
          a = $urandom_range(0, 511);
        end
      endcase
      send_item(r, a, i == samples - 1);
      ang = (ang + 1) % ANGLE_STEPS;
    end
  endtask

  initial begin : stimulus
    int start, gap, wide;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed samples on the reset setting: range 1000, gap 100, width 50..200
    send_item(0, 0, 1);          // empty scan: only a scan end
    send_item(65535, 511, 0);    // beyond range, angle past a full turn
    send_item(1000, 5, 0);       // exactly at max range: dropped
    send_item(999, 359, 0);      // first kept point of the scan
    send_item(300, 90, 0);
    send_item(300, 270, 0);
    send_item(999, 180, 0);
    send_item(500, 0, 0);
    send_item(600, 0, 0);        // gap exactly equal: no open
    send_item(650, 0, 0);        // opens at 600
    send_item(750, 0, 0);        // gap exactly equal: stays open
    send_item(900, 0, 0);        // closes: width 150, center y 675
    send_item(0, 17, 1);
    send_item(500, 0, 0);
    send_item(540, 0, 0);        // opens at 500
    send_item(620, 0, 0);
    send_item(800, 0, 1);        // last sample closes the cluster: center and scan end

    // Zero max range keeps nothing; lowest gap and widths
    apply_setting(0, 0, 0, 0);
    repeat (8) send_noise();
    send_item($urandom_range(1, 65535), $urandom_range(0, 511), 1);

    // Top of every register but the minimum width, which is zero
    apply_setting(65535, 65535, 0, 65535);
    run_scan(30);
    run_scan(30);

    // Hold off the receiver and push a long run of scan ends to back up the block
    apply_setting(1000, 100, 50, 200);
    hold_req   = 1;
    burst_left = 40;
    repeat (30) send_item($urandom_range(0, 65535), $urandom_range(0, 359), 1);

    // Random settings, in proportion to the scene but fully random in the last phase, then mostly well-formed scans
    for (int ph = 0; ph < 5; ph++) begin
      gap = 0;
      if (ph == 4) begin
        apply_setting($urandom_range(1, 65535), $urandom_range(0, 65535),
                      $urandom_range(0, 65535), $urandom_range(0, 65535));
      end else begin
        wide = $urandom_range(400, 8000);
        gap  = wide / $urandom_range(6, 14);
        apply_setting(wide, gap, gap / 2, 2 * gap + $urandom_range(0, gap));
      end
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) == 0) send_noise();
        else run_scan($urandom_range(8, 50));
      end
    end

    // Drain: pop every cycle, wait for the last expected item, then watch for strays
    @(negedge clk);
    push <= 1'b0;
    drain = 1;
    wait (pending == 0);
    repeat (4 * SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d samples over %0d register settings plus reset values;",
             items_sent, settings);
    $display("checked %0d reported clusters and %0d scan ends.", clusters, scans);
    if (pending != 0) $error("%0d expected result items never arrived", pending);
    if (errors == 0 && pending == 0) begin
      $display("scan_point_clustering_top regression: pass");
    end else begin
      $display("scan_point_clustering_top regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/spc_pkg.sv
hdl/spc_fifo.sv
hdl/spc_front.sv
hdl/spc_back.sv
hdl/scan_point_clustering_top.sv
bench/spc_cluster_checker.sv
bench/tb_top.sv
